[design/integer_to_radix_ascii_macros.svh]
// Assertion macros shared by the conversion block.
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

[design/itoa_pkg.sv]
package itoa_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_BASE_DEFAULT = 36;
   localparam int MIN_BASE = 2;
   localparam int DIGIT_W = 6;
   localparam int BASE_W = 6;
   localparam int CHAR_W = 7;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

   typedef struct packed {
      logic done;
      logic quot_zero;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] digit,
                                                input logic upper);
      logic [CHAR_W-1:0] ext;
      ext = CHAR_W'(digit);
      if (digit < DECIMAL_DIGITS) begin
         return CHAR_ZERO + ext;
      end
      return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + ext - CHAR_W'(DECIMAL_DIGITS);
   endfunction

endpackage

[design/itoa_divider.sv]
module itoa_divider
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [BASE_W-1:0]     divisor,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIGIT_W-1:0]    remainder,
   output div_status_type        status
);

   localparam int STEP_W = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIGIT_W:0]      trial;
   logic [DIGIT_W:0]      diff;
   logic                  fits;

   assign trial = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign diff = trial - {1'b0, divisor};
   assign fits = trial >= {1'b0, divisor};

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         step_in = STEP_W'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
   end

   assign quotient = quot_ff;
   assign remainder = rem_ff;
   assign status.done = done_ff;
   assign status.quot_zero = ~|quot_ff;

endmodule

[design/itoa_digit_store.sv]
module itoa_digit_store
   import itoa_pkg::*;
#(
   parameter int DEPTH = VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DIGIT_W-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DIGIT_W-1:0]       rd_data
);

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/integer_to_radix_ascii.sv]
// Converts a signed integer to its ASCII text in a base from 2 to MAX_BASE.
// One item on the req_ channel (req_value, req_base) gives a run of result
// items on the rsp_ channel, most significant character first: a '-' for a
// negative value, then the digits. rsp_last marks the final character. A base
// outside the valid range gives a single item with rsp_base_error set,
// rsp_character zero and rsp_last set.
// csr_upper_case selects upper case letters for digits above nine; it is
// written through the csr_ channel, which is always ready.
// Digits come from a shared restoring divider that produces one quotient bit
// per cycle. After the division each character is read from the digit store
// and then loaded into the output register. req_stall is high from acceptance
// until the last character has been loaded into the output register.
// A stalled result holds in the output register and the sequencer waits.
// Reset clears the sequencer, the output valid and the case register; the
// digit store needs no clearing.
`include "integer_to_radix_ascii_macros.svh"

module integer_to_radix_ascii
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_BASE = MAX_BASE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_upper_case,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [BASE_W-1:0]     req_base,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_character,
   output logic                  rsp_last,
   output logic                  rsp_base_error
);

   localparam int ADDR_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ERROR,
      ST_SIGN,
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic                  neg_ff, neg_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic                  upper_ff, upper_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  req_accept;
   logic                  base_bad;
   logic                  slot_free;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_quot;
   logic [DIGIT_W-1:0]    div_rem;
   div_status_type        div_status;
   logic                  wr_en;
   logic [DIGIT_W-1:0]    rd_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign base_bad = (req_base < BASE_W'(MIN_BASE)) || (req_base > BASE_W'(MAX_BASE));
   assign magnitude = req_value[VALUE_BITS-1] ? (VALUE_BITS'(0) - req_value) : req_value;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign div_dividend = (state_ff == ST_IDLE) ? magnitude : div_quot;
   assign wr_en = (state_ff == ST_DIVIDE) && div_status.done;
   assign csr_ready = 1'b1;
   assign upper_in = (csr_valid && csr_ready) ? csr_upper_case : upper_ff;

   itoa_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (base_ff),
      .quotient (div_quot),
      .remainder(div_rem),
      .status   (div_status)
   );

   itoa_digit_store #(
      .DEPTH(VALUE_BITS)
   ) u_digit_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(div_rem),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      neg_in = neg_ff;
      base_in = base_ff;
      div_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (base_bad) begin
                  state_in = ST_ERROR;
               end else begin
                  neg_in = req_value[VALUE_BITS-1];
                  base_in = req_base;
                  count_in = '0;
                  div_start = 1'b1;
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               count_in = count_ff + CNT_W'(1);
               if (div_status.quot_zero) begin
                  idx_in = count_ff[ADDR_W-1:0];
                  state_in = neg_ff ? ST_SIGN : ST_FETCH;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = CHAR_NUL;
               rsp_last_in = 1'b1;
               rsp_err_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               rsp_err_in = 1'b0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = glyph(rd_data, upper_ff);
               rsp_last_in = (idx_ff == '0);
               rsp_err_in = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - ADDR_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         neg_ff <= 1'b0;
         upper_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         neg_ff <= neg_in;
         upper_ff <= upper_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      base_ff <= base_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_base_error = rsp_err_ff;

   `ASSERT_IMPL(a_error_shape, clock, reset, rsp_valid && rsp_base_error, (rsp_character == CHAR_NUL) && rsp_last)
   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(VALUE_BITS))
   `ASSERT_IMPL(a_done_in_divide, clock, reset, div_status.done, state_ff == ST_DIVIDE)

endmodule

[tb/itoa_text_checker.sv]
module itoa_text_checker
   import itoa_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_upper_case,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [VALUE_BITS_DEFAULT-1:0] req_value,
   input  logic [BASE_W-1:0]             req_base,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [CHAR_W-1:0]             rsp_character,
   input  logic                          rsp_last,
   input  logic                          rsp_base_error,
   output int                            fail_count,
   output int                            pending_count
);

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
      logic              base_error;
   } text_char_type;

   text_char_type expected_text[$];
   text_char_type oldest;
   logic          upper_case_q;
   int            mismatches = 0;

   // Appends the characters that one conversion is expected to produce.
   task automatic predict_text(input logic [VALUE_BITS_DEFAULT-1:0] value,
                               input logic [BASE_W-1:0] base,
                               input logic upper);
      logic [VALUE_BITS_DEFAULT-1:0] rest;
      logic [VALUE_BITS_DEFAULT-1:0] remainder;
      logic [DIGIT_W-1:0]            digits [VALUE_BITS_DEFAULT];
      logic [DIGIT_W-1:0]            d;
      int                            count;
      text_char_type                 item;
      if (base < MIN_BASE || base > MAX_BASE_DEFAULT) begin
         item.character = CHAR_NUL;
         item.last = 1'b1;
         item.base_error = 1'b1;
         expected_text.push_back(item);
      end else begin
         rest = value[VALUE_BITS_DEFAULT-1] ? -value : value;
         count = 0;
         do begin
            remainder = rest % {{(VALUE_BITS_DEFAULT-BASE_W){1'b0}}, base};
            digits[count] = remainder[DIGIT_W-1:0];
            count++;
            rest = rest / {{(VALUE_BITS_DEFAULT-BASE_W){1'b0}}, base};
         end while (rest != 0);
         item.base_error = 1'b0;
         if (value[VALUE_BITS_DEFAULT-1]) begin
            item.character = CHAR_MINUS;
            item.last = 1'b0;
            expected_text.push_back(item);
         end
         for (int i = count; i > 0; i--) begin
            d = digits[i-1];
            if (d < DECIMAL_DIGITS) begin
               item.character = CHAR_ZERO + {1'b0, d};
            end else begin
               item.character = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {1'b0, d}
                                - {1'b0, DECIMAL_DIGITS};
            end
            item.last = (i == 1);
            expected_text.push_back(item);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         upper_case_q <= 1'b0;
         expected_text.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("rsp item with no expected character: character %h last %b error %b",
                      rsp_character, rsp_last, rsp_base_error);
               mismatches++;
            end else begin
               oldest = expected_text.pop_front();
               if (rsp_character !== oldest.character) begin
                  $error("character: expected %h, actual %h", oldest.character,
                         rsp_character);
                  mismatches++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("last: expected %b, actual %b", oldest.last, rsp_last);
                  mismatches++;
               end
               if (rsp_base_error !== oldest.base_error) begin
                  $error("base_error: expected %b, actual %b", oldest.base_error,
                         rsp_base_error);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_text(req_value, req_base, upper_case_q);
         end
         if (csr_valid && csr_ready) begin
            upper_case_q <= csr_upper_case;
         end
         pending_count <= expected_text.size();
      end
      fail_count <= mismatches;
   end

endmodule

[tb/tb.sv]
module tb;
   import itoa_pkg::*;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic                          csr_upper_case = 1'b0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [VALUE_BITS_DEFAULT-1:0] req_value = '0;
   logic [BASE_W-1:0]             req_base = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [CHAR_W-1:0]             rsp_character;
   logic                          rsp_last;
   logic                          rsp_base_error;
   logic                          calm = 1'b0;
   int                            fail_count;
   int                            pending_count;

   integer_to_radix_ascii u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_upper_case (csr_upper_case),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_base       (req_base),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .rsp_base_error (rsp_base_error)
   );

   itoa_text_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_upper_case (csr_upper_case),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_base       (req_base),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .rsp_base_error (rsp_base_error),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #32_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 36);
   end

   task automatic send_item(input logic [VALUE_BITS_DEFAULT-1:0] value,
                            input logic [BASE_W-1:0] base);
      if (!calm) begin
         while ($urandom_range(99) < 36) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_base <= base;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_upper_case(input logic upper);
      csr_valid <= 1'b1;
      csr_upper_case <= upper;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int calm_first, input int calm_last);
      logic [VALUE_BITS_DEFAULT-1:0] value;
      logic [BASE_W-1:0]             base;
      int                            pick;
      for (int n = 0; n < count; n++) begin
         calm <= (n >= calm_first && n < calm_last);
         pick = $urandom_range(99);
         if (pick < 30) begin
            value = $urandom;
         end else if (pick < 55) begin
            value = $urandom >> $urandom_range(31);
         end else if (pick < 70) begin
            value = -($urandom >> $urandom_range(31));
         end else if (pick < 85) begin
            value = $urandom_range(40);
         end else begin
            case ($urandom_range(3))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'hFFFF_FFFF;
               default: value = '0;
            endcase
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            base = BASE_W'($urandom_range(1));
         end else if (pick < 15) begin
            base = BASE_W'($urandom_range(63, 37));
         end else if (pick < 25) begin
            base = 6'd2;
         end else if (pick < 35) begin
            base = 6'd36;
         end else begin
            base = BASE_W'($urandom_range(35, 3));
         end
         send_item(value, base);
      end
      calm <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Letters right after reset must come out in lower case.
      send_item(32'd35, 6'd36);
      send_item(32'hFFFF_FFFF, 6'd36);
      send_item(32'hDEAD_BEEF, 6'd16);
      wait_idle(40);
      write_upper_case(1'b1);

      send_item(32'd0, 6'd10);
      send_item(32'h7FFF_FFFF, 6'd2);
      send_item(32'h8000_0000, 6'd2);
      send_item(32'h8000_0000, 6'd10);
      send_item(32'h8000_0000, 6'd36);
      send_item(32'h7FFF_FFFF, 6'd36);
      send_item(32'hDEAD_BEEF, 6'd16);
      send_item(32'd12345, 6'd3);
      send_item(32'hFFFF_FFFF, 6'd16);
      send_item(32'd1295, 6'd36);
      send_item(32'd0, 6'd36);
      send_item(32'd9, 6'd10);
      send_item(32'h5555_5555, 6'd0);
      send_item(32'hAAAA_AAAA, 6'd1);
      send_item(32'd100, 6'd37);
      send_item(32'h8000_0000, 6'd63);
      send_item(32'hFFFF_FFFF, 6'd42);
      wait_idle(40);
      write_upper_case(1'b0);

      run_random(100, 0, 0);
      wait_idle(40);
      write_upper_case(1'b1);
      run_random(100, 30, 80);
      wait_idle(40);
      write_upper_case(1'b0);
      run_random(100, 0, 0);
      wait_idle(400);

      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/itoa_pkg.sv
design/itoa_divider.sv
design/itoa_digit_store.sv
design/integer_to_radix_ascii.sv
tb/itoa_text_checker.sv
tb/tb.sv
